[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the rtl files; only segment_intersection_test_core includes them.
// ----------------------------------------------------------------------------
// each macro expects clk_i and rst_ni in the scope of the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths and types of the segment intersection test core.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int unsigned FIELD_BITS = 64;
  localparam int unsigned COORD_BITS = 64;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned LO_W       = COORD_BITS / 2;
  localparam int unsigned HI_W       = COORD_BITS - LO_W;
  localparam int unsigned PROD_W     = 2 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [PROD_W-1:0]     prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // sign of a value: neither bit set means positive
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

[rtl/sit_orient.sv]
// ----------------------------------------------------------------------------
// sit_orient
// Exact orientation sign of three points, pipelined over four register stages:
// differences, partial products, product sums, signed compare.
// ----------------------------------------------------------------------------
module sit_orient (
  input  logic            clk_i,
  input  sit_pkg::point_t p_i,
  input  sit_pkg::point_t q_i,
  input  sit_pkg::point_t r_i,
  output sit_pkg::sign_t  sign_o
);

  // stage 1: four differences as sign and magnitude
  sit_pkg::diff_t dv [4];
  sit_pkg::sign_t dsg_d [4];
  sit_pkg::sign_t dsg_q [4];
  sit_pkg::mag_t  mag_d [4];
  sit_pkg::mag_t  mag_q [4];

  always_comb begin
    dv[0] = sit_pkg::diff_t'(q_i.x) - sit_pkg::diff_t'(p_i.x);
    dv[1] = sit_pkg::diff_t'(r_i.y) - sit_pkg::diff_t'(q_i.y);
    dv[2] = sit_pkg::diff_t'(q_i.y) - sit_pkg::diff_t'(p_i.y);
    dv[3] = sit_pkg::diff_t'(r_i.x) - sit_pkg::diff_t'(q_i.x);
    for (int i = 0; i < 4; i++) begin
      dsg_d[i].neg  = dv[i][sit_pkg::DIFF_W-1];
      dsg_d[i].zero = (dv[i] == '0);
      // magnitude never exceeds 2^COORD_BITS - 1
      mag_d[i] = dsg_d[i].neg ? sit_pkg::mag_t'(-dv[i]) : sit_pkg::mag_t'(dv[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    dsg_q <= dsg_d;
    mag_q <= mag_d;
  end

  // stage 2: partial products of both products
  logic [2*sit_pkg::LO_W-1:0]            ll_d [2];
  logic [2*sit_pkg::LO_W-1:0]            ll_q [2];
  logic [sit_pkg::LO_W+sit_pkg::HI_W-1:0] lh_d [2];
  logic [sit_pkg::LO_W+sit_pkg::HI_W-1:0] lh_q [2];
  logic [sit_pkg::LO_W+sit_pkg::HI_W-1:0] hl_d [2];
  logic [sit_pkg::LO_W+sit_pkg::HI_W-1:0] hl_q [2];
  logic [2*sit_pkg::HI_W-1:0]            hh_d [2];
  logic [2*sit_pkg::HI_W-1:0]            hh_q [2];
  sit_pkg::sign_t                        psg_d [2];
  sit_pkg::sign_t                        psg_q [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ll_d[k] = mag_q[2*k][sit_pkg::LO_W-1:0] * mag_q[2*k+1][sit_pkg::LO_W-1:0];
      lh_d[k] = mag_q[2*k][sit_pkg::LO_W-1:0]
              * mag_q[2*k+1][sit_pkg::COORD_BITS-1:sit_pkg::LO_W];
      hl_d[k] = mag_q[2*k][sit_pkg::COORD_BITS-1:sit_pkg::LO_W]
              * mag_q[2*k+1][sit_pkg::LO_W-1:0];
      hh_d[k] = mag_q[2*k][sit_pkg::COORD_BITS-1:sit_pkg::LO_W]
              * mag_q[2*k+1][sit_pkg::COORD_BITS-1:sit_pkg::LO_W];
      psg_d[k].zero = dsg_q[2*k].zero | dsg_q[2*k+1].zero;
      psg_d[k].neg  = ~psg_d[k].zero & (dsg_q[2*k].neg ^ dsg_q[2*k+1].neg);
    end
  end

  always_ff @(posedge clk_i) begin
    ll_q  <= ll_d;
    lh_q  <= lh_d;
    hl_q  <= hl_d;
    hh_q  <= hh_d;
    psg_q <= psg_d;
  end

  // stage 3: full product magnitudes
  sit_pkg::prod_t prod_d [2];
  sit_pkg::prod_t prod_q [2];
  sit_pkg::sign_t prs_q  [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      prod_d[k] = sit_pkg::prod_t'(ll_q[k])
                + (sit_pkg::prod_t'(lh_q[k]) << sit_pkg::LO_W)
                + (sit_pkg::prod_t'(hl_q[k]) << sit_pkg::LO_W)
                + (sit_pkg::prod_t'(hh_q[k]) << (2 * sit_pkg::LO_W));
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    prs_q  <= psg_q;
  end

  // stage 4: sign of first product minus second
  sit_pkg::sign_t sign_d;
  sit_pkg::sign_t sign_q;
  logic           first_above;
  logic           mag_gt;
  logic           mag_eq;

  always_comb begin
    // order of signs is negative, zero, positive
    first_above = (prs_q[1].neg & ~prs_q[0].neg)
                | (prs_q[1].zero & ~prs_q[0].neg & ~prs_q[0].zero);
    mag_gt      = (prod_q[0] > prod_q[1]);
    mag_eq      = (prod_q[0] == prod_q[1]);
    if (prs_q[0] != prs_q[1]) begin
      sign_d.zero = 1'b0;
      sign_d.neg  = ~first_above;
    end else if (prs_q[0].zero || mag_eq) begin
      sign_d.zero = 1'b1;
      sign_d.neg  = 1'b0;
    end else begin
      sign_d.zero = 1'b0;
      sign_d.neg  = prs_q[0].neg ? mag_gt : ~mag_gt;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
  end

  assign sign_o = sign_q;

endmodule

[rtl/sit_box.sv]
// ----------------------------------------------------------------------------
// sit_box
// Registered test of a point against the closed bounding box of a segment.
// ----------------------------------------------------------------------------
module sit_box (
  input  logic            clk_i,
  input  sit_pkg::point_t pt_i,
  input  sit_pkg::point_t s0_i,
  input  sit_pkg::point_t s1_i,
  output logic            inside_o
);

  function automatic logic in_closed(sit_pkg::coord_t v, sit_pkg::coord_t e0,
                                     sit_pkg::coord_t e1);
    sit_pkg::coord_t lo;
    sit_pkg::coord_t hi;
    lo = (e0 > e1) ? e1 : e0;
    hi = (e0 > e1) ? e0 : e1;
    return !(lo > v) && !(v > hi);
  endfunction

  logic inside_d;
  logic inside_q;

  assign inside_d = in_closed(pt_i.x, s0_i.x, s1_i.x)
                  && in_closed(pt_i.y, s0_i.y, s1_i.y);

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
  end

  assign inside_o = inside_q;

endmodule

[rtl/segment_intersection_test_core.sv]
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Exact two-segment intersection predicate with strict and inclusive modes.
// ----------------------------------------------------------------------------
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   request   | start, busy          | a/b start/end x/y (64 b), touch_counts_i
//   result    | done_o (one cycle)   | intersects_o
//
// one request per cycle; busy stays low, so every start is taken
// each result passes the input register, then the four stages of the orientation
// datapath (the 64x64 products split into 32x32 partial products), then the result
// register
// reset clears only the valid pipeline; the data registers are not reset
// results cannot be held off and leave in request order
module segment_intersection_test_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [sit_pkg::FIELD_BITS-1:0]  a_start_x_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  a_start_y_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  a_end_x_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  a_end_y_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  b_start_x_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  b_start_y_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  b_end_x_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  b_end_y_i,
  input  logic                            touch_counts_i,
  output logic                            done_o,
  output logic                            intersects_o
);

  typedef struct packed {
    logic [3:0] on_seg;
    logic       touch;
  } aux_t;

  logic accept;
  logic [5:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept};
    end
  end

  // input register, full field width kept and sign taken from the top
  sit_pkg::point_t as_q, ae_q, bs_q, be_q;
  logic            touch_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      as_q.x  <= a_start_x_i[sit_pkg::COORD_BITS-1:0];
      as_q.y  <= a_start_y_i[sit_pkg::COORD_BITS-1:0];
      ae_q.x  <= a_end_x_i[sit_pkg::COORD_BITS-1:0];
      ae_q.y  <= a_end_y_i[sit_pkg::COORD_BITS-1:0];
      bs_q.x  <= b_start_x_i[sit_pkg::COORD_BITS-1:0];
      bs_q.y  <= b_start_y_i[sit_pkg::COORD_BITS-1:0];
      be_q.x  <= b_end_x_i[sit_pkg::COORD_BITS-1:0];
      be_q.y  <= b_end_y_i[sit_pkg::COORD_BITS-1:0];
      touch_q <= touch_counts_i;
    end
  end

  sit_pkg::sign_t o1, o2, o3, o4;

  sit_orient u_orient_1 (.clk_i, .p_i(as_q), .q_i(ae_q), .r_i(bs_q), .sign_o(o1));
  sit_orient u_orient_2 (.clk_i, .p_i(as_q), .q_i(ae_q), .r_i(be_q), .sign_o(o2));
  sit_orient u_orient_3 (.clk_i, .p_i(bs_q), .q_i(be_q), .r_i(as_q), .sign_o(o3));
  sit_orient u_orient_4 (.clk_i, .p_i(bs_q), .q_i(be_q), .r_i(ae_q), .sign_o(o4));

  logic [3:0] on_seg;

  sit_box u_box_1 (.clk_i, .pt_i(bs_q), .s0_i(as_q), .s1_i(ae_q), .inside_o(on_seg[0]));
  sit_box u_box_2 (.clk_i, .pt_i(be_q), .s0_i(as_q), .s1_i(ae_q), .inside_o(on_seg[1]));
  sit_box u_box_3 (.clk_i, .pt_i(as_q), .s0_i(bs_q), .s1_i(be_q), .inside_o(on_seg[2]));
  sit_box u_box_4 (.clk_i, .pt_i(ae_q), .s0_i(bs_q), .s1_i(be_q), .inside_o(on_seg[3]));

  // keep box flags and mode in step with the orientation pipeline
  logic touch_s_q;
  aux_t aux_q [3];

  always_ff @(posedge clk_i) begin
    touch_s_q <= touch_q;
    aux_q[0]  <= '{on_seg: on_seg, touch: touch_s_q};
    aux_q[1]  <= aux_q[0];
    aux_q[2]  <= aux_q[1];
  end

  logic crossing;
  logic collinear;
  logic touching;
  logic hit;
  logic intersects_q;

  always_comb begin
    crossing  = ~o1.zero & ~o2.zero & (o1.neg ^ o2.neg)
              & ~o3.zero & ~o4.zero & (o3.neg ^ o4.neg);
    collinear = (o1.zero & o2.zero) | (o3.zero & o4.zero);
    touching  = (o1.zero & aux_q[2].on_seg[0]) | (o2.zero & aux_q[2].on_seg[1])
              | (o3.zero & aux_q[2].on_seg[2]) | (o4.zero & aux_q[2].on_seg[3]);
    if (!aux_q[2].touch) begin
      hit = crossing;
    end else if (collinear) begin
      hit = 1'b0;
    end else begin
      hit = touching | crossing;
    end
  end

  always_ff @(posedge clk_i) begin
    intersects_q <= hit;
  end

  assign done_o       = vld_q[5];
  assign intersects_o = intersects_q;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_done_follows_request, done_o, $past(accept, 6),
                "result strobe without a request six cycles earlier")
  `ASSERT_NEXT(a_crossing_hits, vld_q[4] && crossing, intersects_o,
               "strict crossing not reported")
  `ASSERT_NEXT(a_collinear_rejected, vld_q[4] && aux_q[2].touch && collinear,
               !intersects_o, "collinear pair reported in inclusive mode")

endmodule

[test/intersect_checker.sv]
// ----------------------------------------------------------------------------
// intersect_checker
// Watches the request and result channels of the segment intersection core.
// Every accepted request is run through an exact orientation predictor
// (65-bit differences, 130-bit products), and each result strobe is compared
// in order with the oldest prediction. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module intersect_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic [sit_pkg::FIELD_BITS-1:0]  a_start_x_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  a_start_y_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  a_end_x_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  a_end_y_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  b_start_x_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  b_start_y_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  b_end_x_i,
  input  logic [sit_pkg::FIELD_BITS-1:0]  b_end_y_i,
  input  logic                            touch_counts_i,
  input  logic                            done_o,
  input  logic                            intersects_o,
  output int unsigned                     mismatch_cnt_o,
  output int unsigned                     pending_o,
  output int unsigned                     requests_o,
  output int unsigned                     inclusive_o,
  output int unsigned                     hits_o
);

  typedef logic signed [sit_pkg::DIFF_W-1:0]   span_t;
  typedef logic signed [2*sit_pkg::DIFF_W-1:0] area_t;

  typedef struct {
    int unsigned tag;
    logic        inclusive;
    logic        hit;
  } verdict_t;

  verdict_t    intersects_due_q[$];
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned requests;
  int unsigned inclusive_reqs;
  int unsigned hits;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = outstanding;
  assign requests_o     = requests;
  assign inclusive_o    = inclusive_reqs;
  assign hits_o         = hits;

  // sign of the turn p -> q -> r, exact at full coordinate range
  function automatic int turn_sign(sit_pkg::point_t p, sit_pkg::point_t q,
                                   sit_pkg::point_t r);
    span_t ux, uy, vx, vy;
    area_t lhs, rhs;
    ux  = $signed(q.x) - $signed(p.x);
    uy  = $signed(q.y) - $signed(p.y);
    vx  = $signed(r.x) - $signed(q.x);
    vy  = $signed(r.y) - $signed(q.y);
    lhs = ux * vy;
    rhs = uy * vx;
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function automatic logic in_span(sit_pkg::coord_t v, sit_pkg::coord_t e0,
                                   sit_pkg::coord_t e1);
    sit_pkg::coord_t lo, hi;
    lo = (e0 > e1) ? e1 : e0;
    hi = (e0 > e1) ? e0 : e1;
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic in_box(sit_pkg::point_t p, sit_pkg::point_t s0,
                                  sit_pkg::point_t s1);
    return in_span(p.x, s0.x, s1.x) && in_span(p.y, s0.y, s1.y);
  endfunction

  function automatic logic predict_intersects(sit_pkg::point_t as, sit_pkg::point_t ae,
                                              sit_pkg::point_t bs, sit_pkg::point_t be,
                                              logic inclusive);
    int   o1, o2, o3, o4;
    logic crossing;
    o1 = turn_sign(as, ae, bs);
    o2 = turn_sign(as, ae, be);
    o3 = turn_sign(bs, be, as);
    o4 = turn_sign(bs, be, ae);
    crossing = (o1 * o2 < 0) && (o3 * o4 < 0);
    if (!inclusive) return crossing;
    // collinear overlap is rejected before any touch is considered
    if ((o1 == 0 && o2 == 0) || (o3 == 0 && o4 == 0)) return 1'b0;
    if (o1 == 0 && in_box(bs, as, ae)) return 1'b1;
    if (o2 == 0 && in_box(be, as, ae)) return 1'b1;
    if (o3 == 0 && in_box(as, bs, be)) return 1'b1;
    if (o4 == 0 && in_box(ae, bs, be)) return 1'b1;
    return crossing;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t        head;
    verdict_t        due;
    sit_pkg::point_t as, ae, bs, be;
    if (!rst_ni) begin
      intersects_due_q.delete();
      mismatches     = 0;
      outstanding    = 0;
      requests       = 0;
      inclusive_reqs = 0;
      hits           = 0;
    end else begin
      if ($isunknown(done_o)) begin
        flag_mismatch("result strobe is unknown");
      end else if (done_o) begin
        if (intersects_due_q.size() == 0) begin
          flag_mismatch($sformatf("result %0b with no request outstanding", intersects_o));
        end else begin
          head = intersects_due_q.pop_front();
          if (intersects_o !== head.hit)
            flag_mismatch($sformatf(
                "request %0d (touch_counts=%0b): intersects expected %0b, got %b",
                head.tag, head.inclusive, head.hit, intersects_o));
        end
        if (intersects_o === 1'b1) hits++;
      end
      if (start && !busy) begin
        // low COORD_BITS of each field, read as signed by the coordinate type
        as.x = a_start_x_i[sit_pkg::COORD_BITS-1:0];
        as.y = a_start_y_i[sit_pkg::COORD_BITS-1:0];
        ae.x = a_end_x_i[sit_pkg::COORD_BITS-1:0];
        ae.y = a_end_y_i[sit_pkg::COORD_BITS-1:0];
        bs.x = b_start_x_i[sit_pkg::COORD_BITS-1:0];
        bs.y = b_start_y_i[sit_pkg::COORD_BITS-1:0];
        be.x = b_end_x_i[sit_pkg::COORD_BITS-1:0];
        be.y = b_end_y_i[sit_pkg::COORD_BITS-1:0];
        due.tag       = requests;
        due.inclusive = touch_counts_i;
        due.hit       = predict_intersects(as, ae, bs, be, touch_counts_i);
        intersects_due_q.push_back(due);
        requests++;
        if (touch_counts_i) inclusive_reqs++;
      end
      outstanding = intersects_due_q.size();
    end
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the segment intersection core. A directed set of
// crossings, touches, collinear overlaps, degenerate segments and extreme
// coordinates is followed by randomised segment pairs, half of them built on or
// near shared lines so that touches and collinear cases are frequent. The checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned              IDLE_LIMIT   = 400;
  localparam int unsigned              RANDOM_PAIRS = 950;
  localparam logic signed [63:0]       C_MAX        = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0]       C_MIN        = 64'sh8000_0000_0000_0000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic [sit_pkg::FIELD_BITS-1:0]  a_start_x_i;
  logic [sit_pkg::FIELD_BITS-1:0]  a_start_y_i;
  logic [sit_pkg::FIELD_BITS-1:0]  a_end_x_i;
  logic [sit_pkg::FIELD_BITS-1:0]  a_end_y_i;
  logic [sit_pkg::FIELD_BITS-1:0]  b_start_x_i;
  logic [sit_pkg::FIELD_BITS-1:0]  b_start_y_i;
  logic [sit_pkg::FIELD_BITS-1:0]  b_end_x_i;
  logic [sit_pkg::FIELD_BITS-1:0]  b_end_y_i;
  logic                            touch_counts_i;
  logic                            done_o;
  logic                            intersects_o;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned requests;
  int unsigned inclusive_reqs;
  int unsigned hits;
  int unsigned idle_cycles;
  logic        burst;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  segment_intersection_test_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .a_start_x_i    (a_start_x_i),
    .a_start_y_i    (a_start_y_i),
    .a_end_x_i      (a_end_x_i),
    .a_end_y_i      (a_end_y_i),
    .b_start_x_i    (b_start_x_i),
    .b_start_y_i    (b_start_y_i),
    .b_end_x_i      (b_end_x_i),
    .b_end_y_i      (b_end_y_i),
    .touch_counts_i (touch_counts_i),
    .done_o         (done_o),
    .intersects_o   (intersects_o)
  );

  intersect_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .a_start_x_i    (a_start_x_i),
    .a_start_y_i    (a_start_y_i),
    .a_end_x_i      (a_end_x_i),
    .a_end_y_i      (a_end_y_i),
    .b_start_x_i    (b_start_x_i),
    .b_start_y_i    (b_start_y_i),
    .b_end_x_i      (b_end_x_i),
    .b_end_y_i      (b_end_y_i),
    .touch_counts_i (touch_counts_i),
    .done_o         (done_o),
    .intersects_o   (intersects_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .requests_o     (requests),
    .inclusive_o    (inclusive_reqs),
    .hits_o         (hits)
  );

  // watchdog: cycles with neither a request nor a result taken
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int small_int(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one request; inputs change on the falling edge, acceptance seen on the rising
  task automatic drive_pair(input logic signed [63:0] ax0, ay0, ax1, ay1,
                            input logic signed [63:0] bx0, by0, bx1, by1,
                            input logic tc);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    a_start_x_i    <= ax0;
    a_start_y_i    <= ay0;
    a_end_x_i      <= ax1;
    a_end_y_i      <= ay1;
    b_start_x_i    <= bx0;
    b_start_y_i    <= by0;
    b_end_x_i      <= bx1;
    b_end_y_i      <= by1;
    touch_counts_i <= tc;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic both_modes(input logic signed [63:0] ax0, ay0, ax1, ay1,
                            input logic signed [63:0] bx0, by0, bx1, by1);
    drive_pair(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, 1'b0);
    drive_pair(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, 1'b1);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic signed [63:0] p [8];
    logic signed [63:0] base_x, base_y, step, tmp;
    int                 dx, dy, k, j, m, kind;
    rst_ni         = 1'b0;
    start          = 1'b0;
    touch_counts_i = 1'b0;
    a_start_x_i    = '0;
    a_start_y_i    = '0;
    a_end_x_i      = '0;
    a_end_y_i      = '0;
    b_start_x_i    = '0;
    b_start_y_i    = '0;
    b_end_x_i      = '0;
    b_end_y_i      = '0;
    burst          = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: each geometry in strict and inclusive mode
    both_modes(0, 0, 4, 4, 0, 4, 4, 0);                  // plain crossing
    both_modes(0, 0, 4, 0, 2, 0, 2, 3);                  // t-junction touch
    both_modes(0, 0, 2, 2, 2, 2, 4, 0);                  // shared endpoint
    both_modes(0, 0, 4, 0, 2, 0, 6, 0);                  // collinear overlap
    both_modes(1, 1, 1, 1, 0, 0, 2, 2);                  // zero-length segment
    both_modes(0, 0, 4, 0, 0, 1, 4, 1);                  // parallel, apart
    both_modes(0, 0, 2, 2, 3, 3, 3, 0);                  // collinear point off the box
    both_modes(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
    both_modes(C_MIN, C_MIN, C_MAX, C_MIN, 0, C_MIN, 0, C_MAX);
    both_modes(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    both_modes(C_MIN, C_MIN, C_MAX, C_MAX, 0, 1, 1, 0);  // diagonal, off-grid crossing
    drain_results();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          for (int i = 0; i < 8; i++) p[i] = rand64();
        end
        2, 3: begin
          for (int i = 0; i < 8; i++) p[i] = small_int(8);
        end
        4, 5, 6: begin
          // a scaled lattice line through segment a; b_start lies on it, b_end only at times
          step   = 64'sd1 <<< $urandom_range(0, 50);
          base_x = rand64() >>> 3;
          base_y = rand64() >>> 3;
          dx = small_int(4);
          dy = small_int(4);
          if (dx == 0 && dy == 0) dx = 1;
          k = $urandom_range(1, 4);
          j = int'($urandom_range(0, 6)) - 1;
          p[0] = base_x;
          p[1] = base_y;
          p[2] = base_x + k * dx * step;
          p[3] = base_y + k * dy * step;
          p[4] = base_x + j * dx * step;
          p[5] = base_y + j * dy * step;
          if ($urandom_range(0, 3) == 0) begin
            m = int'($urandom_range(0, 6)) - 1;
            p[6] = base_x + m * dx * step;
            p[7] = base_y + m * dy * step;
          end else begin
            p[6] = p[4] + small_int(4) * step;
            p[7] = p[5] + small_int(4) * step;
          end
        end
        7: begin
          for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 7))
              0:       p[i] = C_MIN;
              1:       p[i] = C_MIN + 1;
              2:       p[i] = -1;
              3:       p[i] = 0;
              4:       p[i] = 1;
              5:       p[i] = C_MAX - 1;
              6:       p[i] = C_MAX;
              default: p[i] = rand64();
            endcase
          end
        end
        default: begin
          // large near-collinear points, off the line by at most one unit
          base_x = rand64() >>> 2;
          base_y = rand64() >>> 2;
          dx = $signed($urandom) >>> 2;
          dy = $signed($urandom) >>> 2;
          j  = int'($urandom_range(0, 8)) - 2;
          m  = int'($urandom_range(0, 8)) - 2;
          p[0] = base_x;
          p[1] = base_y;
          p[2] = base_x + 4 * dx;
          p[3] = base_y + 4 * dy;
          p[4] = base_x + j * dx + small_int(1);
          p[5] = base_y + j * dy + small_int(1);
          p[6] = base_x + m * dx + small_int(1);
          p[7] = base_y + m * dy + small_int(1);
        end
      endcase
      // shuffle segment direction and roles so every orientation gets the touch
      if ($urandom_range(0, 1)) begin
        tmp = p[0]; p[0] = p[2]; p[2] = tmp;
        tmp = p[1]; p[1] = p[3]; p[3] = tmp;
      end
      if ($urandom_range(0, 1)) begin
        tmp = p[4]; p[4] = p[6]; p[6] = tmp;
        tmp = p[5]; p[5] = p[7]; p[7] = tmp;
      end
      if ($urandom_range(0, 1)) begin
        for (int i = 0; i < 4; i++) begin
          tmp = p[i]; p[i] = p[i+4]; p[i+4] = tmp;
        end
      end
      drive_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], 1'($urandom_range(0, 1)));
      if (n % 250 == 125) drain_results();
    end

    drain_results();
    repeat (12) @(negedge clk_i);

    $display("covered %0d segment pairs (%0d inclusive, %0d strict), %0d reported intersecting",
             requests, inclusive_reqs, requests - inclusive_reqs, hits);
    $display("%0d mismatches, %0d results still outstanding", mismatch_cnt, pending);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_orient.sv
rtl/sit_box.sv
rtl/segment_intersection_test_core.sv
test/intersect_checker.sv
test/testbench.sv
